// ----- hdl/text_cell_buffer_with_cursor_defines.svh -----
// Assertion macros shared by the RTL of the text cell buffer.
// Define ASSERT_OFF to compile every assertion away.
`ifndef TEXT_CELL_BUFFER_WITH_CURSOR_DEFINES_SVH
`define TEXT_CELL_BUFFER_WITH_CURSOR_DEFINES_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define TCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TCB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/tcb_pkg.sv -----
`timescale 1ns / 1ps
package tcb_pkg;

   // Field widths of the request and response beats.
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 16;
   localparam int ACTION_W   = 3;
   localparam int CUR_COL_W  = 7;
   localparam int CUR_ROW_W  = 6;
   localparam int DIVIDEND_W = BYTE_W + 1;

   // Default geometry of the character store.
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 40;

   // Action codes carried by a request beat.
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT_CHAR   = 3'd0,
      ACT_NEWLINE    = 3'd1,
      ACT_SET_CURSOR = 3'd2,
      ACT_READ_CELL  = 3'd3,
      ACT_CLEAR      = 3'd4,
      ACT_SCROLL     = 3'd5
   } action_type;

   // One character cell as it sits in the store.
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [BYTE_W-1:0]  style;
      logic [BYTE_W-1:0]  code;
   } cell_type;

   // Request to a divider by a fixed divisor.
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
   } div_req_type;

   // Answer of a divider, valid while done is high.
   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [BYTE_W-1:0]     remainder;
   } div_rsp_type;

endpackage

// ----- hdl/text_cell_buffer_with_cursor.sv -----
// Channel   Handshake              Payload
// req       req_valid / req_ready  action, char_code, cell_style, cell_color, col, row,
//                                  scroll_lines
// rsp       rsp_valid / rsp_ready  read_char, read_style, read_color, cursor_col, cursor_row
//
// One request is worked on at a time; each gives one response beat. put_char, newline, a
// zero-line scroll and unused codes go from EXEC straight to DONE; set_cursor and read_cell
// first pass the two registered reciprocal divisions that wrap column and row, and read_cell
// then reads the memory. clear and other scrolls walk the memory. After reset a clearing pass
// runs with req_ready low. A stalled response holds in its register while the next request
// is taken; that one waits at its last step.
`timescale 1ns / 1ps
`include "text_cell_buffer_with_cursor_defines.svh"
module text_cell_buffer_with_cursor #(
   parameter int COLS = tcb_pkg::DEF_COLS,
   parameter int ROWS = tcb_pkg::DEF_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tcb_pkg::ACTION_W-1:0]   req_action,
   input  logic [tcb_pkg::BYTE_W-1:0]     req_char_code,
   input  logic [tcb_pkg::BYTE_W-1:0]     req_cell_style,
   input  logic [tcb_pkg::COLOR_W-1:0]    req_cell_color,
   input  logic [tcb_pkg::BYTE_W-1:0]     req_col,
   input  logic [tcb_pkg::BYTE_W-1:0]     req_row,
   input  logic [tcb_pkg::BYTE_W-1:0]     req_scroll_lines,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcb_pkg::BYTE_W-1:0]     rsp_read_char,
   output logic [tcb_pkg::BYTE_W-1:0]     rsp_read_style,
   output logic [tcb_pkg::COLOR_W-1:0]    rsp_read_color,
   output logic [tcb_pkg::CUR_COL_W-1:0]  rsp_cursor_col,
   output logic [tcb_pkg::CUR_ROW_W-1:0]  rsp_cursor_row
);
   import tcb_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SRC_W = $clog2(2 * CELLS);

   localparam logic [IDX_W-1:0]  COLS_IDX  = IDX_W'(COLS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CELLS - 1);
   localparam logic [SRC_W-1:0]  COLS_SRC  = SRC_W'(COLS);
   localparam logic [SRC_W-1:0]  CELLS_SRC = SRC_W'(CELLS);
   localparam logic [BYTE_W-1:0] ROWS_B    = BYTE_W'(ROWS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_DIV_COL,
      ST_DIV_ROW,
      ST_ADDR,
      ST_RDATA,
      ST_CLEAR,
      ST_SCROLL,
      ST_DONE
   } state_type;

   // Control state.
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic                  div_start_ff, div_start_in;
   logic [COL_W-1:0]      cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic [IDX_W-1:0]      cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]      dst_ff, dst_in;

   // Request beat and working values.
   action_type            act_ff, act_in;
   logic [BYTE_W-1:0]     char_ff, char_in;
   logic [BYTE_W-1:0]     style_ff, style_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [BYTE_W-1:0]     col_ff, col_in;
   logic [BYTE_W-1:0]     row_ff, row_in;
   logic [BYTE_W-1:0]     lines_ff, lines_in;
   logic [COL_W-1:0]      col_w_ff, col_w_in;
   logic [ROW_W-1:0]      row_w_ff, row_w_in;
   logic [SRC_W-1:0]      src_ff, src_in;
   logic [IDX_W-1:0]      wr_addr_ff, wr_addr_in;
   logic                  wr_zero_ff, wr_zero_in;
   logic [DIVIDEND_W-1:0] div_dividend_ff, div_dividend_in;
   cell_type              rd_cell_ff, rd_cell_in;

   // Response register.
   logic [BYTE_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [BYTE_W-1:0]     rsp_style_ff, rsp_style_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic [CUR_COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CUR_ROW_W-1:0]  rsp_row_ff, rsp_row_in;

   // Memory and divider connections.
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   cell_type              ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   cell_type              ram_rd_data;
   div_req_type           div_req;
   div_rsp_type           col_div_rsp;
   div_rsp_type           row_div_rsp;
   logic [IDX_W-1:0]      lin_idx;

   tcb_cell_ram #(
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_dividend_ff;

   // Both dividers see every start; the sequencer takes the answer it waits for.
   tcb_divider #(
      .DIVISOR (COLS)
   ) u_col_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (col_div_rsp)
   );

   tcb_divider #(
      .DIVISOR (ROWS)
   ) u_row_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (row_div_rsp)
   );

   // Linear cell index of the wrapped column and row.
   assign lin_idx = IDX_W'(row_w_ff) * COLS_IDX + IDX_W'(col_w_ff);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      wr_pend_in      = 1'b0;
      div_start_in    = 1'b0;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      cur_idx_in      = cur_idx_ff;
      dst_in          = dst_ff;
      act_in          = act_ff;
      char_in         = char_ff;
      style_in        = style_ff;
      color_in        = color_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      lines_in        = lines_ff;
      col_w_in        = col_w_ff;
      row_w_in        = row_w_ff;
      src_in          = src_ff;
      wr_addr_in      = wr_addr_ff;
      wr_zero_in      = wr_zero_ff;
      div_dividend_in = div_dividend_ff;
      rd_cell_in      = rd_cell_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_style_in    = rsp_style_ff;
      rsp_color_in    = rsp_color_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = dst_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = lin_idx;

      // A taken response beat frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            // Clearing pass after reset.
            ram_wr_en = 1'b1;
            if (dst_ff == LAST_IDX) begin
               dst_in   = '0;
               state_in = ST_IDLE;
            end else begin
               dst_in = dst_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               char_in  = req_char_code;
               style_in = req_cell_style;
               color_in = req_cell_color;
               col_in   = req_col;
               row_in   = req_row;
               lines_in = req_scroll_lines;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_cell_in = '0;
            state_in   = ST_DONE;
            case (act_ff)
               ACT_PUT_CHAR: begin
                  // A zero character ends a string and changes nothing.
                  if (char_ff != '0) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cur_idx_ff;
                     ram_wr_data = '{color: color_ff, style: style_ff, code: char_ff};
                     cur_idx_in  = (cur_idx_ff == LAST_IDX) ? '0 : cur_idx_ff + IDX_W'(1);
                     if (cur_col_ff == LAST_COL) begin
                        cur_col_in = '0;
                        cur_row_in = (cur_row_ff == LAST_ROW) ? '0 : cur_row_ff + ROW_W'(1);
                     end else begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                     end
                  end
               end
               ACT_NEWLINE: begin
                  cur_col_in = '0;
                  if (cur_row_ff == LAST_ROW) begin
                     cur_row_in = '0;
                     cur_idx_in = '0;
                  end else begin
                     cur_row_in = cur_row_ff + ROW_W'(1);
                     cur_idx_in = cur_idx_ff + COLS_IDX - IDX_W'(cur_col_ff);
                  end
               end
               ACT_SET_CURSOR, ACT_READ_CELL: begin
                  div_start_in    = 1'b1;
                  div_dividend_in = {1'b0, col_ff};
                  state_in        = ST_DIV_COL;
               end
               ACT_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  cur_idx_in = '0;
                  dst_in     = '0;
                  state_in   = ST_CLEAR;
               end
               ACT_SCROLL: begin
                  dst_in = '0;
                  if (lines_ff >= ROWS_B) begin
                     state_in = ST_CLEAR;
                  end else if (lines_ff != '0) begin
                     src_in   = SRC_W'(lines_ff) * COLS_SRC;
                     state_in = ST_SCROLL;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DIV_COL: begin
            // The column carry joins the row before it wraps.
            if (col_div_rsp.done) begin
               col_w_in        = COL_W'(col_div_rsp.remainder);
               div_start_in    = 1'b1;
               div_dividend_in = {1'b0, row_ff} + col_div_rsp.quotient;
               state_in        = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (row_div_rsp.done) begin
               row_w_in = ROW_W'(row_div_rsp.remainder);
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (act_ff == ACT_SET_CURSOR) begin
               cur_col_in = col_w_ff;
               cur_row_in = row_w_ff;
               cur_idx_in = lin_idx;
               state_in   = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_RDATA;
            end
         end
         ST_RDATA: begin
            rd_cell_in = ram_rd_data;
            state_in   = ST_DONE;
         end
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (dst_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               dst_in = dst_ff + IDX_W'(1);
            end
         end
         ST_SCROLL: begin
            // Read the source cell now; it is written to its target in the next cycle.
            ram_rd_en   = src_ff < CELLS_SRC;
            ram_rd_addr = IDX_W'(src_ff);
            wr_pend_in  = 1'b1;
            wr_addr_in  = dst_ff;
            wr_zero_in  = src_ff >= CELLS_SRC;
            src_in      = src_ff + SRC_W'(1);
            if (dst_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               dst_in = dst_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_cell_ff.code;
               rsp_style_in = rd_cell_ff.style;
               rsp_color_in = rd_cell_ff.color;
               rsp_col_in   = CUR_COL_W'(cur_col_ff);
               rsp_row_in   = CUR_ROW_W'(cur_row_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write-back of a scrolled cell, in the cycle after its read.
      if (wr_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = wr_zero_ff ? '0 : ram_rd_data;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      char_ff         <= char_in;
      style_ff        <= style_in;
      color_ff        <= color_in;
      col_ff          <= col_in;
      row_ff          <= row_in;
      lines_ff        <= lines_in;
      col_w_ff        <= col_w_in;
      row_w_ff        <= row_w_in;
      src_ff          <= src_in;
      wr_addr_ff      <= wr_addr_in;
      wr_zero_ff      <= wr_zero_in;
      div_dividend_ff <= div_dividend_in;
      rd_cell_ff      <= rd_cell_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_style_ff    <= rsp_style_in;
      rsp_color_ff    <= rsp_color_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_idx_ff   <= '0;
         dst_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         div_start_ff <= div_start_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_idx_ff   <= cur_idx_in;
         dst_ff       <= dst_in;
      end
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_style = rsp_style_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

   // The linear cursor index always agrees with its column and row.
   `TCB_ASSERT_IMP(a_cursor_agrees, clock, reset, 1'b1, IDX_W'(cur_row_ff) * COLS_IDX + IDX_W'(cur_col_ff) == cur_idx_ff, "cursor index differs from column and row")
   // An accepted request blocks the next one: req_ready is low in the cycle after it is taken.
   `TCB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request taken while busy")
   // A scroll write-back never meets a read of the same cell.
   `TCB_ASSERT_IMP(a_scroll_no_overlap, clock, reset, wr_pend_ff && ram_rd_en, wr_addr_ff != ram_rd_addr, "scroll read and write hit one cell")
   // The dividers only answer while the sequencer waits for them.
   `TCB_ASSERT_IMP(a_div_done_expected, clock, reset, col_div_rsp.done || row_div_rsp.done, state_ff == ST_DIV_COL || state_ff == ST_DIV_ROW, "divider result arrived unexpectedly")

endmodule

// ----- hdl/tcb_cell_ram.sv -----
`timescale 1ns / 1ps
module tcb_cell_ram #(
   parameter int DEPTH  = tcb_pkg::DEF_COLS * tcb_pkg::DEF_ROWS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  tcb_pkg::cell_type  wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output tcb_pkg::cell_type  rd_data
);
   import tcb_pkg::*;

   cell_type cell_mem [DEPTH];
   cell_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
   end

   // Single read port with a registered output; the data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tcb_divider.sv -----
`timescale 1ns / 1ps
module tcb_divider #(
   parameter int DIVISOR = tcb_pkg::DEF_COLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcb_pkg::div_req_type div_req,
   output tcb_pkg::div_rsp_type div_rsp
);
   import tcb_pkg::*;

   // Rounded-up reciprocal of the divisor; exact for every dividend of DIVIDEND_W bits.
   localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
   localparam int RECIP_W = DIVIDEND_W + 2;
   localparam int PROD_W  = DIVIDEND_W + RECIP_W;
   localparam logic [RECIP_W-1:0]    RECIP   = RECIP_W'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);
   localparam logic [DIVIDEND_W-1:0] DIV_VAL = DIVIDEND_W'(DIVISOR);

   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [BYTE_W-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]     product;
   logic [DIVIDEND_W-1:0] back;
   logic [DIVIDEND_W-1:0] diff;

   // Quotient by reciprocal multiplication, remainder by one subtraction.
   always_comb begin
      product = PROD_W'(div_req.dividend) * PROD_W'(RECIP);
      quot_in = DIVIDEND_W'(product >> SHIFT);
      back    = quot_in * DIV_VAL;
      diff    = div_req.dividend - back;
      rem_in  = BYTE_W'(diff);
      done_in = div_req.start;
   end

   // The answer is registered, with done raised in the cycle after the start.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
